// ===== rtl/pixel_format_to_rgba_or_gray_macros.svh =====
// Assertion macros used by the top-level RTL module.
`ifndef PIXEL_FORMAT_TO_RGBA_OR_GRAY_MACROS_SVH
`define PIXEL_FORMAT_TO_RGBA_OR_GRAY_MACROS_SVH

`ifndef SYNTHESIS
`define PFRG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PFRG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PFRG_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define PFRG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/pfrg_pkg.sv =====
package pfrg_pkg;

  localparam int PIX_W      = 32;
  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;
  localparam int SUM_W      = 15;
  localparam int RECIP_W    = 13;
  localparam int PROD_W     = SUM_W + RECIP_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SOURCE_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GRAY_MODE     = 2'd1;

  localparam logic [SUM_W-1:0]   LUMA_WR     = 15'd30;
  localparam logic [SUM_W-1:0]   LUMA_WG     = 15'd59;
  localparam logic [SUM_W-1:0]   LUMA_WB     = 15'd11;
  // floor(s / 100) equals (s * 5243) >> 19 for every s below 25600.
  localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;
  localparam int                 RECIP_SHIFT = 19;

  typedef enum logic [1:0] {
    FMT_RGBA8888 = 2'd0,
    FMT_RGB565   = 2'd1,
    FMT_RGBA4444 = 2'd2,
    FMT_A8       = 2'd3
  } fmt_t;

  typedef struct packed {
    fmt_t source_format;
    logic gray_mode;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } rgba_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  function automatic logic [CH_W-1:0] nib17(input logic [3:0] n);
    return {n, n};
  endfunction

  function automatic rgba_t expand_rgba(input fmt_t fmt, input logic [PIX_W-1:0] w);
    rgba_t res;
    res = '0;
    unique case (fmt)
      FMT_RGBA8888: begin
        res = '{red: w[7:0], green: w[15:8], blue: w[23:16], alpha: w[31:24]};
      end
      FMT_RGB565: begin
        res = '{red:   {w[15:11], w[15:13]},
                green: {w[10:5], w[10:9]},
                blue:  {w[4:0], w[4:2]},
                alpha: 8'hFF};
      end
      FMT_RGBA4444: begin
        res = '{red: nib17(w[15:12]), green: nib17(w[11:8]),
                blue: nib17(w[7:4]), alpha: nib17(w[3:0])};
      end
      FMT_A8: begin
        res = '{red: w[7:0], green: w[7:0], blue: w[7:0], alpha: w[7:0]};
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  // A single byte as all three channels gives exactly that byte back as gray.
  function automatic rgb_t luma_src(input fmt_t fmt, input logic [PIX_W-1:0] w);
    rgb_t res;
    res = '0;
    unique case (fmt)
      FMT_RGBA8888: res = '{red: w[7:0], green: w[15:8], blue: w[23:16]};
      FMT_RGB565:   res = '{red: {w[15:11], 3'b000}, green: {w[10:5], 2'b00},
                            blue: {w[4:0], 3'b000}};
      FMT_RGBA4444: res = '{red: nib17(w[15:12]), green: nib17(w[11:8]),
                            blue: nib17(w[7:4])};
      FMT_A8:       res = '{red: w[7:0], green: w[7:0], blue: w[7:0]};
      default:      res = '0;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/pfrg_in_if.sv =====
interface pfrg_in_if;
  logic                        valid;
  logic                        ready;
  logic [pfrg_pkg::PIX_W-1:0]  pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink   (input valid, input pixel_word, output ready);
endinterface

// ===== rtl/pfrg_out_if.sv =====
interface pfrg_out_if;
  logic                       valid;
  logic                       ready;
  logic [pfrg_pkg::CH_W-1:0]  red;
  logic [pfrg_pkg::CH_W-1:0]  green;
  logic [pfrg_pkg::CH_W-1:0]  blue;
  logic [pfrg_pkg::CH_W-1:0]  alpha;
  logic [pfrg_pkg::CH_W-1:0]  gray;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output gray, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input gray, output ready);
endinterface

// ===== rtl/pfrg_cfg.sv =====
module pfrg_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pfrg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [pfrg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output pfrg_pkg::cfg_t                  cfg
);

  pfrg_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{source_format: pfrg_pkg::FMT_RGBA8888, gray_mode: 1'b0};
    end else if (cfg_we) begin
      unique case (cfg_idx)
        pfrg_pkg::CFG_IDX_SOURCE_FORMAT: begin
          cfg_r.source_format <= pfrg_pkg::fmt_t'(cfg_wdata[1:0]);
        end
        pfrg_pkg::CFG_IDX_GRAY_MODE: begin
          cfg_r.gray_mode <= cfg_wdata[0];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/pixel_format_to_rgba_or_gray.sv =====
// Each accepted input beat gives one result beat on the output, in order.
// Throughput: one pixel per cycle; four register stages (expand, weighted sum,
// reciprocal multiply, output) each stall only when full and blocked downstream.
// Reset (rst_n, synchronous, active low) clears all stage valid bits and sets
// source_format to RGBA8888 and gray_mode to off.
`include "pixel_format_to_rgba_or_gray_macros.svh"

module pixel_format_to_rgba_or_gray (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pfrg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [pfrg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  pfrg_in_if.sink                         in_pix,
  pfrg_out_if.source                      out_pix
);

  pfrg_pkg::cfg_t cfg;

  pfrg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  pfrg_pkg::rgba_t                   rgba1_r, rgba2_r, rgba3_r, rgba4_r;
  pfrg_pkg::rgb_t                    src1_r;
  logic                              gm1_r, gm2_r, gm3_r;
  logic [pfrg_pkg::SUM_W-1:0]        sum2_r;
  logic [pfrg_pkg::PROD_W-1:0]       prod3_r;
  logic [pfrg_pkg::CH_W-1:0]         gray4_r;

  pfrg_pkg::rgba_t                   rgba_nxt;
  logic [pfrg_pkg::SUM_W-1:0]        sum_nxt;
  logic [pfrg_pkg::CH_W-1:0]         gray_nxt;

  assign rdy4 = !v4_r || out_pix.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_pix.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_pix.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_comb begin
    rgba_nxt = cfg.gray_mode ? '0
                             : pfrg_pkg::expand_rgba(cfg.source_format, in_pix.pixel_word);
    sum_nxt  = pfrg_pkg::LUMA_WR * pfrg_pkg::SUM_W'(src1_r.red)
             + pfrg_pkg::LUMA_WG * pfrg_pkg::SUM_W'(src1_r.green)
             + pfrg_pkg::LUMA_WB * pfrg_pkg::SUM_W'(src1_r.blue);
    gray_nxt = gm3_r ? prod3_r[pfrg_pkg::RECIP_SHIFT +: pfrg_pkg::CH_W] : '0;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      rgba1_r <= rgba_nxt;
      src1_r  <= pfrg_pkg::luma_src(cfg.source_format, in_pix.pixel_word);
      gm1_r   <= cfg.gray_mode;
    end
    if (rdy2) begin
      rgba2_r <= rgba1_r;
      sum2_r  <= sum_nxt;
      gm2_r   <= gm1_r;
    end
    if (rdy3) begin
      rgba3_r <= rgba2_r;
      prod3_r <= pfrg_pkg::PROD_W'(sum2_r) * pfrg_pkg::PROD_W'(pfrg_pkg::RECIP_100);
      gm3_r   <= gm2_r;
    end
    if (rdy4) begin
      rgba4_r <= rgba3_r;
      gray4_r <= gray_nxt;
    end
  end

  assign out_pix.valid = v4_r;
  assign out_pix.red   = rgba4_r.red;
  assign out_pix.green = rgba4_r.green;
  assign out_pix.blue  = rgba4_r.blue;
  assign out_pix.alpha = rgba4_r.alpha;
  assign out_pix.gray  = gray4_r;

  `PFRG_ASSERT_NEXT(a_stage_advance, clk, rst_n, v1_r && rdy2, v2_r)
  `PFRG_ASSERT_NEXT(a_hold_rgba, clk, rst_n, v4_r && !out_pix.ready, v4_r && $stable(rgba4_r))
  `PFRG_ASSERT_NEXT(a_hold_gray, clk, rst_n, v4_r && !out_pix.ready, $stable(gray4_r))
  `PFRG_ASSERT_NOW(a_gray_zero_in_rgba, clk, rst_n, v3_r && !gm3_r, gray_nxt == '0)
  `PFRG_ASSERT_NOW(a_rgba_zero_in_gray, clk, rst_n, v1_r && gm1_r, rgba1_r == '0)

endmodule

// ===== tb/pixel_format_to_rgba_or_gray_tb.sv =====
module pixel_format_to_rgba_or_gray_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [pfrg_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
  localparam logic [pfrg_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;
  localparam int ITEMS_PER_SETTING = 44;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [pfrg_pkg::CH_W-1:0] red;
    logic [pfrg_pkg::CH_W-1:0] green;
    logic [pfrg_pkg::CH_W-1:0] blue;
    logic [pfrg_pkg::CH_W-1:0] alpha;
    logic [pfrg_pkg::CH_W-1:0] gray;
  } pixel_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [pfrg_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [pfrg_pkg::CFG_DATA_W-1:0] cfg_wdata;

  pfrg_in_if in_ch();
  pfrg_out_if out_ch();

  pixel_format_to_rgba_or_gray u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_pix(in_ch),
    .out_pix(out_ch)
  );

  pfrg_pkg::fmt_t cur_fmt;
  logic cur_gray;
  pixel_result_t pending_pixels[$];
  int in_idle_pct;
  int out_idle_pct;
  int pixels_sent;
  int results_checked;
  int fault_count;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.pixel_word = '0;
    out_ch.ready = 1'b0;
    cur_fmt = pfrg_pkg::FMT_RGBA8888;
    cur_gray = 1'b0;
    in_idle_pct = 24;
    out_idle_pct = 50;
    pixels_sent = 0;
    results_checked = 0;
    fault_count = 0;
    stall_cycles = 0;
  end

  always #6 clk = ~clk;

  function automatic logic [pfrg_pkg::CH_W-1:0] luminance(input int unsigned r,
                                                          input int unsigned g,
                                                          input int unsigned b);
    return pfrg_pkg::CH_W'((30 * r + 59 * g + 11 * b) / 100);
  endfunction

  function automatic pixel_result_t convert_pixel(input pfrg_pkg::fmt_t fmt,
                                                  input logic gray_on,
                                                  input logic [pfrg_pkg::PIX_W-1:0] w);
    pixel_result_t res;
    int unsigned r5;
    int unsigned g6;
    int unsigned b5;
    res = '0;
    r5 = w[15:11];
    g6 = w[10:5];
    b5 = w[4:0];
    if (gray_on) begin
      case (fmt)
        pfrg_pkg::FMT_RGBA8888: res.gray = luminance(w[7:0], w[15:8], w[23:16]);
        pfrg_pkg::FMT_RGB565:   res.gray = luminance(r5 * 8, g6 * 4, b5 * 8);
        pfrg_pkg::FMT_RGBA4444: res.gray = luminance(w[15:12] * 17, w[11:8] * 17,
                                                     w[7:4] * 17);
        default:                res.gray = w[7:0];
      endcase
    end else begin
      case (fmt)
        pfrg_pkg::FMT_RGBA8888: begin
          res.red = w[7:0];
          res.green = w[15:8];
          res.blue = w[23:16];
          res.alpha = w[31:24];
        end
        pfrg_pkg::FMT_RGB565: begin
          res.red = pfrg_pkg::CH_W'((r5 << 3) | (r5 >> 2));
          res.green = pfrg_pkg::CH_W'((g6 << 2) | (g6 >> 4));
          res.blue = pfrg_pkg::CH_W'((b5 << 3) | (b5 >> 2));
          res.alpha = 8'hFF;
        end
        pfrg_pkg::FMT_RGBA4444: begin
          res.red = pfrg_pkg::CH_W'(w[15:12] * 17);
          res.green = pfrg_pkg::CH_W'(w[11:8] * 17);
          res.blue = pfrg_pkg::CH_W'(w[7:4] * 17);
          res.alpha = pfrg_pkg::CH_W'(w[3:0] * 17);
        end
        default: begin
          res.red = w[7:0];
          res.green = w[7:0];
          res.blue = w[7:0];
          res.alpha = w[7:0];
        end
      endcase
    end
    return res;
  endfunction

  function automatic logic [pfrg_pkg::PIX_W-1:0] random_word();
    logic [pfrg_pkg::PIX_W-1:0] w;
    w = $urandom;
    case ($urandom_range(9))
      0: w = '0;
      1: w = '1;
      2: begin
        for (int i = 0; i < 4; i++) begin
          w[i*8 +: 8] = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    pixel_result_t exp_px;
    pixel_result_t got_px;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_px = '{red: out_ch.red, green: out_ch.green, blue: out_ch.blue,
                 alpha: out_ch.alpha, gray: out_ch.gray};
      if (pending_pixels.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
          $display("Unexpected result beat: r=%02h g=%02h b=%02h a=%02h y=%02h",
                   got_px.red, got_px.green, got_px.blue, got_px.alpha, got_px.gray);
        end
      end else begin
        exp_px = pending_pixels.pop_front();
        if (got_px.red !== exp_px.red || got_px.green !== exp_px.green ||
            got_px.blue !== exp_px.blue || got_px.alpha !== exp_px.alpha ||
            got_px.gray !== exp_px.gray) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS) begin
            $display("Mismatch on result %0d: expected r=%02h g=%02h b=%02h a=%02h y=%02h",
                     results_checked, exp_px.red, exp_px.green, exp_px.blue, exp_px.alpha,
                     exp_px.gray);
            $display("  got r=%02h g=%02h b=%02h a=%02h y=%02h", got_px.red, got_px.green,
                     got_px.blue, got_px.alpha, got_px.gray);
          end
        end
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles.", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [pfrg_pkg::PIX_W-1:0] w);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pixel_word <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_pixels.push_back(convert_pixel(cur_fmt, cur_gray, w));
    pixels_sent++;
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [pfrg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pfrg_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pfrg_pkg::CFG_IDX_SOURCE_FORMAT: cur_fmt = pfrg_pkg::fmt_t'(data);
      pfrg_pkg::CFG_IDX_GRAY_MODE:     cur_gray = data[0];
      default: ;
    endcase
  endtask

  task automatic set_mode(input pfrg_pkg::fmt_t fmt, input logic gray_on);
    drain_pipeline();
    write_reg(pfrg_pkg::CFG_IDX_SOURCE_FORMAT, fmt);
    write_reg(pfrg_pkg::CFG_IDX_GRAY_MODE, {1'b0, gray_on});
  endtask

  task automatic test_reset_state();
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h1234_5678);
  endtask

  task automatic test_format_extremes();
    for (int k = 0; k < 8; k++) begin
      set_mode(pfrg_pkg::fmt_t'(k[1:0]), k[2]);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h0000_0000);
    end
  endtask

  task automatic test_register_edges();
    set_mode(pfrg_pkg::FMT_RGB565, 1'b0);
    write_reg(pfrg_pkg::CFG_IDX_GRAY_MODE, 2'b11);
    send_pixel(32'hA5A5_F81F);
    drain_pipeline();
    write_reg(pfrg_pkg::CFG_IDX_GRAY_MODE, 2'b10);
    send_pixel(32'h5A5A_07E0);
    drain_pipeline();
    write_reg(CFG_IDX_SPARE2, 2'b11);
    write_reg(CFG_IDX_SPARE3, 2'b10);
    send_pixel(32'hFFFF_8410);
    send_pixel(32'h0000_7BEF);
  endtask

  task automatic test_random_stream();
    int start;
    int s;
    for (int phase = 0; phase < 3; phase++) begin
      drain_pipeline();
      case (phase)
        0: begin
          in_idle_pct = 24;
          out_idle_pct = 50;
        end
        1: begin
          in_idle_pct = 50;
          out_idle_pct = 24;
        end
        default: begin
          in_idle_pct = 0;
          out_idle_pct = 0;
        end
      endcase
      start = $urandom_range(7);
      for (int k = 0; k < 8; k++) begin
        s = (k + start) % 8;
        set_mode(pfrg_pkg::fmt_t'(s[1:0]), s[2]);
        for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
          send_pixel(random_word());
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_format_extremes();
    test_register_edges();
    test_random_stream();
    drain_pipeline();
    repeat (8) @(negedge clk);
    $display("Sent %0d pixels over all source formats and both output modes; %0d checked.",
             pixels_sent, results_checked);
    $display("Stall mixes: sender-heavy, receiver-heavy, none; odd register writes included.");
    if (fault_count == 0 && pending_pixels.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pfrg_pkg.sv
rtl/pfrg_in_if.sv
rtl/pfrg_out_if.sv
rtl/pfrg_cfg.sv
rtl/pixel_format_to_rgba_or_gray.sv
tb/pixel_format_to_rgba_or_gray_tb.sv
